// ===== sv/bend_sensor_calibrate_and_map_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Bend sensor unit assertion macros
// Clocked assertion helpers, empty when synthesising.
// ---------------------------------------------------------------------------
`ifndef BEND_SENSOR_CALIBRATE_AND_MAP_UNIT_DEFINES_SVH
`define BEND_SENSOR_CALIBRATE_AND_MAP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BSCM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define BSCM_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define BSCM_ASSERT(lbl, clk, rstn, prop)
`define BSCM_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== sv/bscm_pkg.sv =====
// ---------------------------------------------------------------------------
// Bend sensor package
// Shared constants, codes and types.
// ---------------------------------------------------------------------------
package bscm_pkg;
    localparam int NCH = 5;
    localparam logic [11:0] WIN_MAX_RESET = 12'd200;
    localparam logic [11:0] WIN_MIN_RESET = 12'd30;
    localparam logic [11:0] MV_HIGH_LIMIT = 12'd3295;
    localparam logic [11:0] MV_LOW_LIMIT  = 12'd5;
    localparam logic [6:0]  SPAN_MIN_FIRST = 7'd50;
    localparam logic [6:0]  SPAN_MIN_OTHER = 7'd70;
    localparam logic [2:0]  DIV_TOP_BIT = 3'd6;

    typedef enum logic [1:0] {
        FN_MAP = 2'd0, FN_TRACK = 2'd1, FN_FINISH = 2'd2, FN_RAW = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CS_NONE = 2'd0, CS_FAIL = 2'd1, CS_DONE = 2'd2
    } t_check;

    typedef enum logic [1:0] {
        ST_IDLE, ST_SETUP, ST_DIV, ST_OUT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       setup;
        logic       div_en;
        logic [2:0] div_bit;
        logic [1:0] func;
        logic       active;
        logic       commit;
    } t_lane_ctrl;

    typedef struct packed {
        logic range_ok;
        logic wide;
    } t_lane_stat;
endpackage

// ===== sv/bscm_lane.sv =====
// ---------------------------------------------------------------------------
// Bend sensor channel lane
// Millivolt conversion, window and track state, bit-serial angle divider.
// ---------------------------------------------------------------------------
module bscm_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bscm_pkg::t_lane_ctrl i_ctrl,
    input  logic [11:0]          i_raw,
    input  logic [6:0]           i_span_min,
    output bscm_pkg::t_lane_stat o_stat,
    output logic [11:0]          o_mv,
    output logic [7:0]           o_angle
);
    logic [11:0] r_wmax, r_wmin, r_tmax, r_tmin, r_mv;
    logic [11:0] n_tmax, n_tmin;
    logic [1:0]  r_func;
    logic [22:0] r_rem;
    logic [15:0] r_den;
    logic [6:0]  r_q;
    logic        r_upper, r_zero;

    logic [11:0] mv_c, x_lo, x, d, s;
    logic [16:0] d20, s7, diff;
    logic [12:0] span;
    logic [12:0] sp_f, sp_c;
    logic [22:0] shifted;

    assign mv_c = 12'((24'(i_raw) * 24'd3300) >> 12);

    assign span = {1'b0, r_tmax} - {1'b0, r_tmin};
    assign sp_f = 13'((26'(span) * 26'd3277) >> 16);
    assign sp_c = 13'((26'(span + 13'd19) * 26'd3277) >> 16);

    assign o_stat.range_ok = (r_tmax <= bscm_pkg::MV_HIGH_LIMIT)
                          && (r_tmin >= bscm_pkg::MV_LOW_LIMIT);
    assign o_stat.wide = {1'b0, r_tmax} >= ({1'b0, r_tmin} + 13'(i_span_min));

    always_comb begin
        n_tmax = r_tmax;
        n_tmin = r_tmin;
        if (!i_ctrl.active) begin
            n_tmax = mv_c;
            n_tmin = mv_c;
        end else begin
            if (r_tmax <= mv_c) n_tmax = mv_c;
            if (r_tmin >= mv_c) n_tmin = mv_c;
        end
    end

    always_comb begin
        x_lo = (r_mv < r_wmin) ? r_wmin : r_mv;
        x    = (x_lo > r_wmax) ? r_wmax : x_lo;
        d    = x - r_wmin;
        s    = r_wmax - r_wmin;
        d20  = 17'(d) * 17'd20;
        s7   = 17'(s) * 17'd7;
        diff = d20 - s7;
    end

    assign shifted = 23'(r_den) << i_ctrl.div_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wmax <= bscm_pkg::WIN_MAX_RESET;
            r_wmin <= bscm_pkg::WIN_MIN_RESET;
            r_tmax <= '0;
            r_tmin <= '0;
        end else if (i_ctrl.commit) begin
            r_tmax <= r_tmax - sp_c[11:0];
            r_tmin <= r_tmin + sp_f[11:0];
            r_wmax <= r_tmax - sp_c[11:0];
            r_wmin <= r_tmin + sp_f[11:0];
        end else if (i_ctrl.load && i_ctrl.func == bscm_pkg::FN_TRACK) begin
            r_tmax <= n_tmax;
            r_tmin <= n_tmin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_mv   <= mv_c;
            r_func <= i_ctrl.func;
        end
        if (i_ctrl.setup) begin
            r_zero  <= r_wmax <= r_wmin;
            r_upper <= !(d20 < s7);
            r_q     <= '0;
            if (d20 < s7) begin
                r_rem <= 23'(d) * 23'd1800;
                r_den <= 16'(s7);
            end else begin
                r_rem <= 23'(diff) * 23'd90;
                r_den <= 16'(17'(s) * 17'd13);
            end
        end else if (i_ctrl.div_en) begin
            if (r_rem >= shifted) begin
                r_rem <= r_rem - shifted;
                r_q   <= r_q | 7'(7'd1 << i_ctrl.div_bit);
            end
        end
    end

    assign o_mv = r_mv;
    always_comb begin
        if (r_func != bscm_pkg::FN_MAP || r_zero) o_angle = '0;
        else if (r_upper) o_angle = 8'd90 + 8'(r_q);
        else o_angle = 8'(r_q);
    end
endmodule

// ===== sv/bend_sensor_calibrate_and_map_unit.sv =====
// ---------------------------------------------------------------------------
// Bend sensor calibrate and map unit
// Five parallel lanes convert, track and map; a merge stage forms status.
// ---------------------------------------------------------------------------
// channel  | dir | tdata                         | tuser
// s_axis   | in  | raw_ch0..raw_ch4 (12b each)   | func (2b)
// m_axis   | out | angle_ch0..4 (8b), mv_ch0..4  | check_status (2b), committed
//
// The result becomes valid after one setup step and then seven divider steps
// (one quotient bit per cycle in each lane). The result is held until taken;
// input is ready again the cycle after the result transfer. Input is ready
// only when no item is in flight. Synchronous active-low reset restores
// windows 200/30, tracks 0.
module bend_sensor_calibrate_and_map_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // raw_ch0..raw_ch4, 12b each, pad
    input  logic [1:0]   s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // angle_ch0..4 8b, mv_ch0..4 12b, pad
    output logic [2:0]   m_axis_tuser   // check_status 2b, committed
);
`include "bend_sensor_calibrate_and_map_unit_defines.svh"

    bscm_pkg::t_state r_state, n_state;
    logic [2:0] r_bit;
    logic       r_active;
    logic [1:0] r_status;
    logic       r_commit;
    logic       accept, fail, wide;
    bscm_pkg::t_lane_ctrl ctrl;
    bscm_pkg::t_lane_stat stat [bscm_pkg::NCH];
    logic [11:0] mv    [bscm_pkg::NCH];
    logic [7:0]  angle [bscm_pkg::NCH];

    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        fail = 1'b0;
        wide = 1'b1;
        for (int i = 0; i < bscm_pkg::NCH; i++) begin
            if (!stat[i].range_ok) fail = 1'b1;
            if (!stat[i].wide) wide = 1'b0;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        ctrl.load     = accept;
        ctrl.setup    = 1'b0;
        ctrl.div_en   = 1'b0;
        ctrl.div_bit  = r_bit;
        ctrl.func     = s_axis_tuser;
        ctrl.active   = r_active;
        ctrl.commit   = accept && s_axis_tuser == bscm_pkg::FN_FINISH && !fail && wide;
        unique case (r_state)
            bscm_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) n_state = bscm_pkg::ST_SETUP;
            end
            bscm_pkg::ST_SETUP: begin
                ctrl.setup = 1'b1;
                n_state    = bscm_pkg::ST_DIV;
            end
            bscm_pkg::ST_DIV: begin
                ctrl.div_en = 1'b1;
                if (r_bit == 3'd0) n_state = bscm_pkg::ST_OUT;
            end
            bscm_pkg::ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) n_state = bscm_pkg::ST_IDLE;
            end
            default: n_state = bscm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bscm_pkg::ST_IDLE;
            r_active <= 1'b0;
            r_bit    <= bscm_pkg::DIV_TOP_BIT;
        end else begin
            r_state <= n_state;
            if (r_state == bscm_pkg::ST_DIV) r_bit <= r_bit - 3'd1;
            else r_bit <= bscm_pkg::DIV_TOP_BIT;
            if (accept && s_axis_tuser == bscm_pkg::FN_TRACK) r_active <= 1'b1;
            if (accept && s_axis_tuser == bscm_pkg::FN_FINISH) r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_commit <= ctrl.commit;
            if (s_axis_tuser != bscm_pkg::FN_FINISH) r_status <= bscm_pkg::CS_NONE;
            else if (fail) r_status <= bscm_pkg::CS_FAIL;
            else r_status <= bscm_pkg::CS_DONE;
        end
    end

    for (genvar g = 0; g < bscm_pkg::NCH; g++) begin : g_lane
        bscm_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_raw      (s_axis_tdata[g*12 +: 12]),
            .i_span_min ((g == 0) ? bscm_pkg::SPAN_MIN_FIRST : bscm_pkg::SPAN_MIN_OTHER),
            .o_stat     (stat[g]),
            .o_mv       (mv[g]),
            .o_angle    (angle[g])
        );
        assign m_axis_tdata[g*8 +: 8]       = angle[g];
        assign m_axis_tdata[40 + g*12 +: 12] = mv[g];
    end
    assign m_axis_tdata[103:100] = '0;
    assign m_axis_tuser = {r_commit, r_status};

    `BSCM_ASSERT(a_commit_done, i_clk, i_rst_n, m_axis_tvalid && r_commit |-> r_status == bscm_pkg::CS_DONE)
    `BSCM_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, accept, !s_axis_tready && !m_axis_tvalid)
    `BSCM_ASSERT(a_one_side, i_clk, i_rst_n, !(s_axis_tready && m_axis_tvalid))
endmodule
